[rtl/core/aeps_pkg.sv]
`default_nettype none
package aeps_pkg;

  // request codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_NEXT = 1'b1;

  localparam int OUT_ID_W = 8;
  localparam int PRIO_W   = 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  // memory strobes from the queue control to the entry store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // per-item result flags decided in the accept cycle
  typedef struct packed {
    logic              grant_valid;
    logic              banks_swapped;
    logic              add_accepted;
    logic [PRIO_W-1:0] new_prio;
    logic              went_expired;
  } res_t;

endpackage
`default_nettype wire

[rtl/core/aeps_entry_mem.sv]
`default_nettype none
module aeps_entry_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 10
) (
  input  wire logic              clk,
  input  wire aeps_pkg::mem_ctl_t ctl_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire logic [DW-1:0]     wdata_i,
  output logic      [DW-1:0]     rdata_o
);
  import aeps_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_r <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule
`default_nettype wire

[rtl/core/aeps_queue_ctl.sv]
`default_nettype none
module aeps_queue_ctl #(
  parameter int LEVELS     = 4,
  parameter int FIFO_DEPTH = 16,
  parameter int AW         = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept_i,
  input  wire logic               req_type_i,
  input  wire logic [2:0]         static_prio_i,
  input  wire logic [1:0]         dyn_prio_i,
  input  wire logic               fresh_i,
  output aeps_pkg::res_t          res_o,
  output aeps_pkg::mem_ctl_t      mem_o,
  output logic      [AW-1:0]      addr_o
);
  import aeps_pkg::*;

  localparam int NQ = 2 * LEVELS;
  localparam int LW = $clog2(LEVELS);
  localparam int QW = $clog2(NQ);
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [PW-1:0] head_r [NQ];
  logic [PW-1:0] tail_r [NQ];
  logic [CW-1:0] cnt_r  [NQ];
  logic          active_r;

  logic [PW-1:0] head_nxt [NQ];
  logic [PW-1:0] tail_nxt [NQ];
  logic [CW-1:0] cnt_nxt  [NQ];
  logic          active_nxt;

  // add path
  logic          is_exp;
  logic [2:0]    raw_prio;
  logic [LW-1:0] np;
  logic [LW-1:0] add_lvl;
  logic [QW-1:0] add_q;
  logic          add_ok;

  // next path
  logic          act_empty, exp_empty, swap, pop_bank, found;
  logic [LW-1:0] pop_lvl;
  logic [QW-1:0] pop_q;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    is_exp = !fresh_i && (dyn_prio_i == 2'd0);
    if (is_exp) begin
      raw_prio = (static_prio_i == 3'd0) ? 3'd0 : static_prio_i - 3'd1;
    end else if (fresh_i) begin
      raw_prio = {1'b0, dyn_prio_i};
    end else begin
      raw_prio = {1'b0, dyn_prio_i - 2'd1};
    end
    if (int'(raw_prio) > LEVELS - 1) begin
      np = LW'(LEVELS - 1);
    end else begin
      np = LW'(raw_prio);
    end
    // FIFO 0 of a bank holds the top priority
    add_lvl = LW'(LEVELS - 1) - np;
    add_q   = QW'(is_exp ^ active_r) * QW'(LEVELS) + QW'(add_lvl);
    add_ok  = (cnt_r[add_q] != CW'(FIFO_DEPTH));
  end

  always_comb begin
    act_empty = 1'b1;
    exp_empty = 1'b1;
    for (int l = 0; l < LEVELS; l++) begin
      if (active_r) begin
        if (cnt_r[LEVELS + l] != '0) act_empty = 1'b0;
        if (cnt_r[l] != '0)          exp_empty = 1'b0;
      end else begin
        if (cnt_r[l] != '0)          act_empty = 1'b0;
        if (cnt_r[LEVELS + l] != '0) exp_empty = 1'b0;
      end
    end
    swap     = act_empty && !exp_empty;
    pop_bank = active_r ^ swap;
    found    = 1'b0;
    pop_lvl  = '0;
    // highest nonempty level, scanned so the lowest index wins
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if ((pop_bank ? cnt_r[LEVELS + l] : cnt_r[l]) != '0) begin
        found   = 1'b1;
        pop_lvl = LW'(l);
      end
    end
    pop_q = QW'(pop_bank) * QW'(LEVELS) + QW'(pop_lvl);
  end

  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      head_nxt[q] = head_r[q];
      tail_nxt[q] = tail_r[q];
      cnt_nxt[q]  = cnt_r[q];
    end
    active_nxt = active_r;
    mem_o      = '0;
    res_o      = '0;
    addr_o     = AW'(pop_q) * AW'(FIFO_DEPTH) + AW'(head_r[pop_q]);
    if (accept_i) begin
      case (req_type_i)
        REQ_ADD: begin
          addr_o             = AW'(add_q) * AW'(FIFO_DEPTH) + AW'(tail_r[add_q]);
          res_o.new_prio     = PRIO_W'(np);
          res_o.went_expired = is_exp;
          res_o.add_accepted = add_ok;
          if (add_ok) begin
            mem_o.wr_en     = 1'b1;
            tail_nxt[add_q] = next_slot(tail_r[add_q]);
            cnt_nxt[add_q]  = cnt_r[add_q] + CW'(1);
          end
        end
        REQ_NEXT: begin
          res_o.banks_swapped = swap;
          res_o.grant_valid   = found;
          active_nxt          = pop_bank;
          if (found) begin
            mem_o.rd_en     = 1'b1;
            head_nxt[pop_q] = next_slot(head_r[pop_q]);
            cnt_nxt[pop_q]  = cnt_r[pop_q] - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < NQ; q++) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        cnt_r[q]  <= '0;
      end
      active_r <= 1'b0;
    end else begin
      for (int q = 0; q < NQ; q++) begin
        head_r[q] <= head_nxt[q];
        tail_r[q] <= tail_nxt[q];
        cnt_r[q]  <= cnt_nxt[q];
      end
      active_r <= active_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/active_expired_priority_scheduler_top.sv]
`default_nettype none
// Active/expired priority scheduler.
// Input: an item is taken at a rising edge with start high and busy low.
//   in_req_type 0 adds task in_task_id with the priority derived from
//   in_static_prio, in_dyn_prio and in_fresh; 1 asks for the next task.
// Output: one result per item, shown for exactly one cycle with out_valid
//   high, in the cycle right after the item is taken. The receiver cannot
//   stall, so the result must be sampled in that cycle.
// Items: busy is high during the result cycle, so no new item is taken
//   while a result is shown; the entry store read is synchronous.
// Storage: one entry store of 2*LEVELS*FIFO_DEPTH words (id + priority),
//   one FIFO per bank and level; head, tail and fill count per FIFO in flops.
//   A pop reads the entry at the head; an add writes at the tail.
// Reset: synchronous, active low. Clears all FIFO pointers and counts and
//   makes bank zero active; the entry store is not cleared since a slot is
//   only read after it was written. No clearing pass, the block is ready
//   in the first cycle after reset.
module active_expired_priority_scheduler_top #(
  parameter int LEVELS     = 4,
  parameter int FIFO_DEPTH = 16,
  parameter int ID_BITS    = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_task_id,
  input  wire logic [2:0] in_static_prio,
  input  wire logic [1:0] in_dyn_prio,
  input  wire logic       in_fresh,
  output logic            out_valid,
  output logic            out_grant_valid,
  output logic [7:0]      out_grant_id,
  output logic [1:0]      out_grant_prio,
  output logic            out_banks_swapped,
  output logic            out_add_accepted,
  output logic [1:0]      out_new_prio,
  output logic            out_went_expired
);
  import aeps_pkg::*;

  localparam int NQ    = 2 * LEVELS;
  localparam int DEPTH = NQ * FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  // ids are carried on an 8-bit port, so at most 8 bits are ever kept
  localparam int IW    = (ID_BITS < OUT_ID_W) ? ID_BITS : OUT_ID_W;
  localparam int DW    = IW + PRIO_W;

  state_t state_r, state_nxt;
  res_t   res_now, res_r;
  mem_ctl_t mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [DW-1:0] mem_rdata;
  logic          accept;

  assign busy   = (state_r == ST_RESP);
  assign accept = start && !busy;

  aeps_queue_ctl #(
    .LEVELS     (LEVELS),
    .FIFO_DEPTH (FIFO_DEPTH),
    .AW         (AW)
  ) u_ctl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept_i      (accept),
    .req_type_i    (in_req_type),
    .static_prio_i (in_static_prio),
    .dyn_prio_i    (in_dyn_prio),
    .fresh_i       (in_fresh),
    .res_o         (res_now),
    .mem_o         (mem_ctl),
    .addr_o        (mem_addr)
  );

  // entry word: {id, priority}; priority from the item's computed value
  aeps_entry_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i ({in_task_id[IW-1:0], res_now.new_prio}),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_now;
    end
  end

  assign out_valid         = busy;
  assign out_grant_valid   = res_r.grant_valid;
  assign out_grant_id      = res_r.grant_valid ? OUT_ID_W'(mem_rdata[DW-1:PRIO_W]) : '0;
  assign out_grant_prio    = res_r.grant_valid ? mem_rdata[PRIO_W-1:0] : '0;
  assign out_banks_swapped = res_r.banks_swapped;
  assign out_add_accepted  = res_r.add_accepted;
  assign out_new_prio      = res_r.new_prio;
  assign out_went_expired  = res_r.went_expired;

endmodule
`default_nettype wire
